/* src/mpq_pkg.sv */
`default_nettype none

package mpq_pkg;

    localparam int CAPACITY    = 1024;
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int CHILD_W     = ADDR_W + 1;
    localparam int KEY_W       = 64;
    localparam int COUNT_OUT_W = 11;
    localparam int ERR_W       = 2;

    localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP,
        ST_LAST,
        ST_DN_L,
        ST_DN_R,
        ST_FIN
    } t_state;

endpackage

`default_nettype wire

/* src/min_priority_queue.sv */
`default_nettype none

// Channel   Direction  Handshake                    Payload
// request   in         i_in_valid / o_in_ready      i_opcode, i_value
// result    out        o_out_valid / i_out_ready    o_min_value, o_extracted_value,
//                                                   o_extracted_valid, o_element_count,
//                                                   o_error_code
//
// One request at a time. Insert: done at once when empty or full, else the key climbs level
// by level until it stops or reaches the root. Extract: done at once when empty or on the
// last key, else the last key is fetched into the root hole, then the hole sinks level by
// level with one read per child, and a final write when it reaches a leaf.
// The single read port of the key RAM sets these steps; the result then passes through the
// pending flag into the output register. Synchronous reset empties the queue; no clearing pass.
// A stalled result holds in the output register while the next request finishes.

module min_priority_queue
    import mpq_pkg::*;
(
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic                          i_opcode,
    input  wire logic signed [KEY_W-1:0]       i_value,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic signed      [KEY_W-1:0]       o_min_value,
    output logic signed      [KEY_W-1:0]       o_extracted_value,
    output logic                               o_extracted_valid,
    output logic             [COUNT_OUT_W-1:0] o_element_count,
    output logic             [ERR_W-1:0]       o_error_code
);

    function automatic logic [ADDR_W-1:0] parent_of(input logic [ADDR_W-1:0] p);
        return (p - 1'b1) >> 1;
    endfunction

    t_state r_state, n_state;

    logic [CNT_W-1:0]        r_count, n_count;
    logic signed [KEY_W-1:0] r_root, n_root;
    logic signed [KEY_W-1:0] r_key, n_key;
    logic signed [KEY_W-1:0] r_left, n_left;
    logic [ADDR_W-1:0]       r_pos, n_pos;
    logic                    r_pend, n_pend;
    logic signed [KEY_W-1:0] r_ext, n_ext;
    logic                    r_ext_vld, n_ext_vld;
    logic [ERR_W-1:0]        r_err, n_err;

    logic                    r_ovalid;
    logic signed [KEY_W-1:0] r_omin, r_oext;
    logic                    r_oext_vld;
    logic [COUNT_OUT_W-1:0]  r_ocount;
    logic [ERR_W-1:0]        r_oerr;

    logic                    w_we;
    logic [ADDR_W-1:0]       w_waddr, w_raddr;
    logic signed [KEY_W-1:0] w_wdata, w_rdata;

    logic                    w_accept, w_out_free, w_done;
    logic                    w_full, w_empty;
    logic [CNT_W-1:0]        w_cnt_dec;
    logic [ADDR_W-1:0]       w_parent;
    logic                    w_up_less;
    logic [CHILD_W-1:0]      w_left_idx, w_right_idx, w_pick_idx, w_next_child;
    logic                    w_has_right;
    logic signed [KEY_W-1:0] w_pick_val;
    logic                    w_move, w_child_ok;

    mpq_ram #(
        .WIDTH(KEY_W),
        .DEPTH(CAPACITY)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign o_in_ready = (r_state == ST_IDLE) && !r_pend;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_ovalid || i_out_ready;

    assign w_full    = (r_count >= CNT_W'(CAPACITY));
    assign w_empty   = (r_count == '0);
    assign w_cnt_dec = r_count - 1'b1;
    assign w_parent  = parent_of(r_pos);
    assign w_up_less = (r_key < w_rdata);

    // children of the current hole
    assign w_left_idx  = {r_pos, 1'b1};
    assign w_right_idx = w_left_idx + 1'b1;
    assign w_has_right = (w_right_idx < CHILD_W'(r_count));

    // smaller child: right only exists in ST_DN_R
    always_comb begin
        if (r_state == ST_DN_R && w_rdata < r_left) begin
            w_pick_val = w_rdata;
            w_pick_idx = w_right_idx;
        end else if (r_state == ST_DN_R) begin
            w_pick_val = r_left;
            w_pick_idx = w_left_idx;
        end else begin
            w_pick_val = w_rdata;
            w_pick_idx = w_left_idx;
        end
    end

    assign w_move       = (w_pick_val < r_key);
    assign w_next_child = {w_pick_idx[ADDR_W-1:0], 1'b1};
    assign w_child_ok   = (w_next_child < CHILD_W'(r_count));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_opcode == OP_INSERT) begin
                        if (!w_full && !w_empty) begin
                            n_state = ST_UP;
                        end
                    end else if (!w_empty && w_cnt_dec != '0) begin
                        n_state = ST_LAST;
                    end
                end
            end
            ST_UP: begin
                if (!w_up_less) begin
                    n_state = ST_IDLE;
                end else if (w_parent == '0) begin
                    n_state = ST_FIN;
                end
            end
            ST_LAST: begin
                n_state = (CHILD_W'(1) < CHILD_W'(r_count)) ? ST_DN_L : ST_IDLE;
            end
            ST_DN_L, ST_DN_R: begin
                if (r_state == ST_DN_L && w_has_right) begin
                    n_state = ST_DN_R;
                end else if (!w_move) begin
                    n_state = ST_IDLE;
                end else if (w_child_ok) begin
                    n_state = ST_DN_L;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_count   = r_count;
        n_key     = r_key;
        n_left    = r_left;
        n_pos     = r_pos;
        n_ext     = r_ext;
        n_ext_vld = r_ext_vld;
        n_err     = r_err;
        w_done    = 1'b0;
        w_we      = 1'b0;
        w_waddr   = r_pos;
        w_wdata   = r_key;
        w_raddr   = w_parent;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_ext     = '0;
                    n_ext_vld = 1'b0;
                    n_err     = ERR_OK;
                    if (i_opcode == OP_INSERT) begin
                        if (w_full) begin
                            n_err  = ERR_FULL;
                            w_done = 1'b1;
                        end else begin
                            n_count = r_count + 1'b1;
                            n_key   = i_value;
                            n_pos   = r_count[ADDR_W-1:0];
                            w_raddr = parent_of(r_count[ADDR_W-1:0]);
                            if (w_empty) begin
                                w_we    = 1'b1;
                                w_waddr = '0;
                                w_wdata = i_value;
                                w_done  = 1'b1;
                            end
                        end
                    end else if (w_empty) begin
                        n_err  = ERR_EMPTY;
                        w_done = 1'b1;
                    end else begin
                        n_ext     = r_root;
                        n_ext_vld = 1'b1;
                        n_count   = w_cnt_dec;
                        w_raddr   = w_cnt_dec[ADDR_W-1:0];
                        if (w_cnt_dec == '0) begin
                            w_done = 1'b1;
                        end
                    end
                end
            end
            ST_UP: begin
                w_we = 1'b1;
                if (w_up_less) begin
                    w_wdata = w_rdata;
                    n_pos   = w_parent;
                    w_raddr = parent_of(w_parent);
                end else begin
                    w_done = 1'b1;
                end
            end
            ST_LAST: begin
                // last key drops into the root hole
                n_key   = w_rdata;
                n_pos   = '0;
                w_raddr = ADDR_W'(1);
                if (!(CHILD_W'(1) < CHILD_W'(r_count))) begin
                    w_we    = 1'b1;
                    w_waddr = '0;
                    w_wdata = w_rdata;
                    w_done  = 1'b1;
                end
            end
            ST_DN_L, ST_DN_R: begin
                if (r_state == ST_DN_L && w_has_right) begin
                    n_left  = w_rdata;
                    w_raddr = w_right_idx[ADDR_W-1:0];
                end else begin
                    w_we = 1'b1;
                    if (w_move) begin
                        w_wdata = w_pick_val;
                        n_pos   = w_pick_idx[ADDR_W-1:0];
                        w_raddr = w_next_child[ADDR_W-1:0];
                    end else begin
                        w_done = 1'b1;
                    end
                end
            end
            ST_FIN: begin
                w_we   = 1'b1;
                w_done = 1'b1;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    assign n_root = (w_we && w_waddr == '0) ? w_wdata : r_root;
    assign n_pend = w_done || (r_pend && !w_out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
            if (r_pend && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_root    <= n_root;
        r_key     <= n_key;
        r_left    <= n_left;
        r_pos     <= n_pos;
        r_ext     <= n_ext;
        r_ext_vld <= n_ext_vld;
        r_err     <= n_err;
        if (r_pend && w_out_free) begin
            r_omin     <= w_empty ? KEY_MAX : r_root;
            r_oext     <= r_ext;
            r_oext_vld <= r_ext_vld;
            r_ocount   <= COUNT_OUT_W'(r_count);
            r_oerr     <= r_err;
        end
    end

    assign o_out_valid       = r_ovalid;
    assign o_min_value       = r_omin;
    assign o_extracted_value = r_oext;
    assign o_extracted_valid = r_oext_vld;
    assign o_element_count   = r_ocount;
    assign o_error_code      = r_oerr;

endmodule

`default_nettype wire

/* src/mpq_ram.sv */
`default_nettype none

module mpq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* test/min_priority_queue_tb.sv */
`default_nettype none

module min_priority_queue_tb;
    import mpq_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 40;

    localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
    localparam logic signed [KEY_W-1:0] KEY_TOP = KEY_MAX - 1;

    typedef struct {
        logic signed [KEY_W-1:0] min_value;
        logic signed [KEY_W-1:0] extracted_value;
        logic                    extracted_valid;
        logic [COUNT_OUT_W-1:0]  element_count;
        logic [ERR_W-1:0]        error_code;
    } t_queue_result;

    logic                          i_clk;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_ready;
    logic                          i_opcode = OP_INSERT;
    logic signed [KEY_W-1:0]       i_value = '0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    logic signed [KEY_W-1:0]       o_min_value;
    logic signed [KEY_W-1:0]       o_extracted_value;
    logic                          o_extracted_valid;
    logic [COUNT_OUT_W-1:0]        o_element_count;
    logic [ERR_W-1:0]              o_error_code;

    // keys the queue should hold, in arrival order
    logic signed [KEY_W-1:0] held_keys[$];
    t_queue_result           expected_results[$];

    bit idle_on = 1'b1;
    int stall_left = 0;
    int cycle_count = 0;
    int mismatches = 0;
    int insert_count = 0;
    int extract_count = 0;
    int full_drops = 0;
    int empty_extracts = 0;
    int peak_count = 0;

    min_priority_queue u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_opcode          (i_opcode),
        .i_value           (i_value),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_min_value       (o_min_value),
        .o_extracted_value (o_extracted_value),
        .o_extracted_valid (o_extracted_valid),
        .o_element_count   (o_element_count),
        .o_error_code      (o_error_code)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int lowest_key_index();
        int best;
        best = 0;
        for (int i = 1; i < held_keys.size(); i++) begin
            if (held_keys[i] < held_keys[best])
                best = i;
        end
        return best;
    endfunction

    function automatic t_queue_result apply_queue_op(input logic op,
                                                     input logic signed [KEY_W-1:0] key);
        t_queue_result r;
        int idx;
        r.extracted_value = '0;
        r.extracted_valid = 1'b0;
        r.error_code      = ERR_OK;
        if (op == OP_INSERT) begin
            insert_count++;
            if (held_keys.size() >= CAPACITY) begin
                r.error_code = ERR_FULL;
                full_drops++;
            end else begin
                held_keys.insert(held_keys.size(), key);
            end
        end else begin
            extract_count++;
            if (held_keys.size() == 0) begin
                r.error_code = ERR_EMPTY;
                empty_extracts++;
            end else begin
                idx = lowest_key_index();
                r.extracted_value = held_keys[idx];
                r.extracted_valid = 1'b1;
                held_keys.delete(idx);
            end
        end
        if (held_keys.size() > peak_count)
            peak_count = held_keys.size();
        r.min_value     = (held_keys.size() > 0) ? held_keys[lowest_key_index()] : KEY_MAX;
        r.element_count = COUNT_OUT_W'(held_keys.size());
        return r;
    endfunction

    // mix of wide random keys, a narrow band that makes duplicates, and extremes
    function automatic logic signed [KEY_W-1:0] random_key();
        logic signed [KEY_W-1:0] k;
        case ($urandom_range(0, 9))
            0, 1: begin
                k = KEY_W'($urandom_range(0, 15));
                k = k - 64'sd8;
            end
            2: begin
                case ($urandom_range(0, 3))
                    0: k = KEY_MIN;
                    1: k = KEY_TOP;
                    2: k = '0;
                    default: k = '1;
                endcase
            end
            default: k = {$urandom, $urandom};
        endcase
        if (k == KEY_MAX)
            k = KEY_TOP;
        return k;
    endfunction

    task automatic log_failure(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0d] %s", cycle_count, msg);
    endtask

    task automatic check_field(input string name, input logic signed [KEY_W-1:0] want,
                               input logic signed [KEY_W-1:0] got);
        if (got !== want)
            log_failure($sformatf("%s mismatch: expected %0d, got %0d", name, want, got));
    endtask

    // one request; valid stays high into the next call unless a gap is taken
    task automatic send_request(input logic op, input logic signed [KEY_W-1:0] key);
        t_queue_result res;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_value    <= key;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        res = apply_queue_op(op, key);
        expected_results.insert(expected_results.size(), res);
    endtask

    task automatic test_directed_edges();
        idle_on = 1'b1;
        send_request(OP_EXTRACT, '0);
        send_request(OP_INSERT, KEY_MIN);
        send_request(OP_INSERT, KEY_TOP);
        send_request(OP_INSERT, '0);
        send_request(OP_INSERT, '1);
        send_request(OP_INSERT, 64'sd5);
        send_request(OP_INSERT, 64'sd5);
        send_request(OP_INSERT, 64'sh5555_5555_5555_5555);
        send_request(OP_INSERT, 64'shAAAA_AAAA_AAAA_AAAA);
        repeat (8) send_request(OP_EXTRACT, {$urandom, $urandom});
        send_request(OP_EXTRACT, KEY_TOP);
        send_request(OP_INSERT, -64'sd3);
        send_request(OP_EXTRACT, KEY_MIN);
        send_request(OP_EXTRACT, '1);
    endtask

    task automatic test_random_mixed();
        idle_on = 1'b1;
        for (int i = 0; i < 450; i++) begin
            if (i == 150)
                idle_on = 1'b0;
            if (i == 220)
                idle_on = 1'b1;
            send_request(($urandom_range(0, 1) == 0) ? OP_INSERT : OP_EXTRACT, random_key());
        end
    endtask

    // mostly inserts until the store is full, then a few that must be dropped
    task automatic test_fill_to_capacity();
        idle_on = 1'b1;
        while (held_keys.size() < CAPACITY)
            send_request(($urandom_range(0, 99) < 95) ? OP_INSERT : OP_EXTRACT, random_key());
        repeat (4) send_request(OP_INSERT, random_key());
    endtask

    task automatic test_full_boundary();
        idle_on = 1'b0;
        repeat (100)
            send_request(($urandom_range(0, 99) < 60) ? OP_INSERT : OP_EXTRACT, random_key());
    endtask

    // result side: random stall bursts while idling is on
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= $urandom_range(0, 5);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_queue_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                log_failure($sformatf("result with nothing pending: min %0d count %0d",
                                      o_min_value, o_element_count));
            end else begin
                want = expected_results.pop_front();
                check_field("min_value", want.min_value, o_min_value);
                check_field("extracted_value", want.extracted_value, o_extracted_value);
                check_field("extracted_valid", KEY_W'(want.extracted_valid),
                            KEY_W'(o_extracted_valid));
                check_field("element_count", KEY_W'(want.element_count),
                            KEY_W'(o_element_count));
                check_field("error_code", KEY_W'(want.error_code), KEY_W'(o_error_code));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout with %0d results pending", expected_results.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_edges();
        test_random_mixed();
        test_fill_to_capacity();
        test_full_boundary();

        i_in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d inserts and %0d extracts, peak occupancy %0d of %0d.",
                 insert_count, extract_count, peak_count, CAPACITY);
        $display("Dropped inserts on full queue: %0d, extracts on empty queue: %0d.",
                 full_drops, empty_extracts);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
src/mpq_pkg.sv
src/mpq_ram.sv
src/min_priority_queue.sv
test/min_priority_queue_tb.sv
